### design/bresenham_line_pixel_generator_macros.svh
// Assertion macros for the Bresenham line pixel generator.
// Used by the top level; the enclosing module supplies clk_i and rst_ni.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define BLPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BLPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/blpg_pkg.sv
// Shared types and constants of the Bresenham line pixel generator.
// No dependencies; imported by every module of the block.
package blpg_pkg;

  localparam int CoordBits  = 11;
  localparam int ColorBits  = 8;
  localparam int StrideBits = 13;
  localparam int OffsetBits = 23;
  localparam int DecBits    = CoordBits + 3;
  localparam int IncBits    = CoordBits + 2;
  localparam int ProdBits   = StrideBits + CoordBits;

  localparam logic [StrideBits-1:0] StrideReset = StrideBits'(720);

  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [CoordBits-1:0] x_a;
    logic [CoordBits-1:0] y_a;
    logic [CoordBits-1:0] x_b;
    logic [CoordBits-1:0] y_b;
    logic [ColorBits-1:0] color_in;
  } blpg_in_t;

  typedef struct packed {
    logic [CoordBits-1:0]  pixel_x;
    logic [CoordBits-1:0]  pixel_y;
    logic [OffsetBits-1:0] pixel_offset;
    logic [ColorBits-1:0]  pixel_color;
    logic                  last_pixel;
  } blpg_out_t;

  // Classified command handed from the front end to the stepper.
  typedef struct packed {
    logic                        op;
    logic                        major_is_x;
    logic                        minor_down;
    logic                        last;
    logic [CoordBits-1:0]        cur_x;
    logic [CoordBits-1:0]        cur_y;
    logic [CoordBits-1:0]        end_major;
    logic signed [DecBits-1:0]   decision;
    logic [IncBits-1:0]          inc_straight;
    logic signed [DecBits-1:0]   inc_diagonal;
    logic [ColorBits-1:0]        color;
  } blpg_cmd_t;

endpackage

### design/blpg_front.sv
// Front end: classifies input transactions and computes the line set-up.
// Depends on blpg_pkg; feeds blpg_queue.
module blpg_front (
  input  blpg_pkg::blpg_in_t  in_data_i,
  output blpg_pkg::blpg_cmd_t cmd_o
);
  import blpg_pkg::*;

  logic [CoordBits-1:0] dx, dy, pa, pb, qa, qb, dmaj, dmin;
  logic                 x_desc, y_desc, major_x, swap;
  logic [DecBits-1:0]   dmin2, dmaj2;

  always_comb begin
    x_desc  = in_data_i.x_a > in_data_i.x_b;
    y_desc  = in_data_i.y_a > in_data_i.y_b;
    dx      = x_desc ? in_data_i.x_a - in_data_i.x_b : in_data_i.x_b - in_data_i.x_a;
    dy      = y_desc ? in_data_i.y_a - in_data_i.y_b : in_data_i.y_b - in_data_i.y_a;
    major_x = dx > dy;
    swap    = major_x ? x_desc : y_desc;
    if (major_x) begin
      pa = in_data_i.x_a; pb = in_data_i.x_b;
      qa = in_data_i.y_a; qb = in_data_i.y_b;
      dmaj = dx; dmin = dy;
    end else begin
      pa = in_data_i.y_a; pb = in_data_i.y_b;
      qa = in_data_i.x_a; qb = in_data_i.x_b;
      dmaj = dy; dmin = dx;
    end
    // Walk from the endpoint with the lower major coordinate.
    if (swap) begin
      {pa, pb} = {pb, pa};
      {qa, qb} = {qb, qa};
    end
    dmin2 = {2'b00, dmin, 1'b0};
    dmaj2 = {2'b00, dmaj, 1'b0};

    cmd_o.op           = in_data_i.op;
    cmd_o.major_is_x   = major_x;
    cmd_o.minor_down   = qb < qa;
    cmd_o.last         = pa == pb;
    cmd_o.cur_x        = major_x ? pa : qa;
    cmd_o.cur_y        = major_x ? qa : pa;
    cmd_o.end_major    = pb;
    cmd_o.decision     = $signed(dmin2 - {3'b000, dmaj});
    cmd_o.inc_straight = {1'b0, dmin, 1'b0};
    cmd_o.inc_diagonal = $signed(dmin2 - dmaj2);
    cmd_o.color        = in_data_i.color_in;
  end

endmodule

### design/blpg_queue.sv
// Short command queue between the front end and the stepper.
// Depends on blpg_pkg for the command type.
module blpg_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  blpg_pkg::blpg_cmd_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output blpg_pkg::blpg_cmd_t head_o
);
  import blpg_pkg::*;

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  blpg_cmd_t            mem_q [DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = count_q == CntBits'(DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### design/blpg_back.sv
// Back end: Bresenham stepper, offset multiplier stage and output register.
// Depends on blpg_pkg; pops commands from blpg_queue.
module blpg_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [blpg_pkg::StrideBits-1:0]       stride_i,
  input  logic                                  cmd_valid_i,
  input  blpg_pkg::blpg_cmd_t                   cmd_i,
  output logic                                  cmd_pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output blpg_pkg::blpg_out_t                   out_data_o
);
  import blpg_pkg::*;

  // Line state.
  logic                      busy_q, busy_d;
  logic                      major_x_q, major_x_d, minor_down_q, minor_down_d;
  logic [CoordBits-1:0]      cur_x_q, cur_x_d, cur_y_q, cur_y_d, end_major_q, end_major_d;
  logic signed [DecBits-1:0] decision_q, decision_d, inc_diag_q, inc_diag_d;
  logic [IncBits-1:0]        inc_str_q, inc_str_d;
  logic [ColorBits-1:0]      color_q, color_d;

  // Pixel stage.
  logic                      pix_valid_q, pix_valid_d, pix_last_q, pix_last_d;
  logic [CoordBits-1:0]      pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic [ColorBits-1:0]      pix_color_q, pix_color_d;

  // Multiply stage.
  logic                      mul_valid_q, mul_last_q;
  logic [CoordBits-1:0]      mul_x_q, mul_y_q;
  logic [ColorBits-1:0]      mul_color_q;
  logic [OffsetBits-1:0]     mul_prod_q;
  logic [ProdBits-1:0]       prod;

  logic                      out_valid_q;
  blpg_out_t                 out_q;

  logic                      adv;
  logic [CoordBits-1:0]      maj, maj_n, mnr, mnr_n;
  logic                      step_last;

  // The whole pipeline moves together; it holds only while the output is stalled.
  assign adv       = !(out_valid_q && out_stall_i);
  assign cmd_pop_o = cmd_valid_i && adv;

  always_comb begin
    maj       = major_x_q ? cur_x_q : cur_y_q;
    mnr       = major_x_q ? cur_y_q : cur_x_q;
    maj_n     = maj + 1'b1;
    mnr_n     = minor_down_q ? mnr - 1'b1 : mnr + 1'b1;
    step_last = maj_n == end_major_q;

    busy_d       = busy_q;
    major_x_d    = major_x_q;
    minor_down_d = minor_down_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    end_major_d  = end_major_q;
    decision_d   = decision_q;
    inc_str_d    = inc_str_q;
    inc_diag_d   = inc_diag_q;
    color_d      = color_q;
    pix_valid_d  = 1'b0;
    pix_last_d   = 1'b0;

    if (cmd_pop_o) begin
      if (cmd_i.op == OpStart) begin
        // A new line replaces any line still running.
        major_x_d    = cmd_i.major_is_x;
        minor_down_d = cmd_i.minor_down;
        cur_x_d      = cmd_i.cur_x;
        cur_y_d      = cmd_i.cur_y;
        end_major_d  = cmd_i.end_major;
        decision_d   = cmd_i.decision;
        inc_str_d    = cmd_i.inc_straight;
        inc_diag_d   = cmd_i.inc_diagonal;
        color_d      = cmd_i.color;
        busy_d       = !cmd_i.last;
        pix_valid_d  = 1'b1;
        pix_last_d   = cmd_i.last;
      end else if (busy_q) begin
        if (decision_q[DecBits-1]) begin
          decision_d = decision_q + $signed({1'b0, inc_str_q});
        end else begin
          decision_d = decision_q + inc_diag_q;
          if (major_x_q) begin
            cur_y_d = mnr_n;
          end else begin
            cur_x_d = mnr_n;
          end
        end
        if (major_x_q) begin
          cur_x_d = maj_n;
        end else begin
          cur_y_d = maj_n;
        end
        busy_d      = !step_last;
        pix_valid_d = 1'b1;
        pix_last_d  = step_last;
      end
    end
    pix_x_d     = cur_x_d;
    pix_y_d     = cur_y_d;
    pix_color_d = color_d;
  end

  assign prod = stride_i * pix_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pix_valid_q <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (adv) begin
        pix_valid_q <= pix_valid_d;
        mul_valid_q <= pix_valid_q;
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    major_x_q    <= major_x_d;
    minor_down_q <= minor_down_d;
    cur_x_q      <= cur_x_d;
    cur_y_q      <= cur_y_d;
    end_major_q  <= end_major_d;
    decision_q   <= decision_d;
    inc_str_q    <= inc_str_d;
    inc_diag_q   <= inc_diag_d;
    color_q      <= color_d;
    if (adv) begin
      pix_last_q   <= pix_last_d;
      pix_x_q      <= pix_x_d;
      pix_y_q      <= pix_y_d;
      pix_color_q  <= pix_color_d;
      mul_last_q   <= pix_last_q;
      mul_x_q      <= pix_x_q;
      mul_y_q      <= pix_y_q;
      mul_color_q  <= pix_color_q;
      mul_prod_q   <= prod[OffsetBits-1:0];
      out_q.pixel_x      <= mul_x_q;
      out_q.pixel_y      <= mul_y_q;
      out_q.pixel_offset <= mul_prod_q + OffsetBits'(mul_x_q);
      out_q.pixel_color  <= mul_color_q;
      out_q.last_pixel   <= mul_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/bresenham_line_pixel_generator.sv
// Bresenham line pixel generator: start or step transactions, one pixel per clock
// unless the output stalls. A transaction goes through the command queue, then the
// pixel, multiply and output registers. The stepper takes one transaction per cycle
// unless the output stalls; its loop is one add and compare on the decision variable.
// Reset clears all valid flags, queue pointers and the busy flag; the stride returns to 720.
`include "bresenham_line_pixel_generator_macros.svh"

module bresenham_line_pixel_generator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  blpg_pkg::blpg_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output blpg_pkg::blpg_out_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [blpg_pkg::StrideBits-1:0] cfg_wdata_i
);
  import blpg_pkg::*;

  logic [StrideBits-1:0] stride_q;
  blpg_cmd_t             front_cmd, head_cmd;
  logic                  q_full, q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= StrideReset;
    end else if (cfg_we_i) begin
      stride_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = q_full;

  blpg_front u_front (
    .in_data_i (in_data_i),
    .cmd_o     (front_cmd)
  );

  blpg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_cmd)
  );

  blpg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stride_i    (stride_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A queued command must move on whenever the output side is not holding.
  `BLPG_ASSERT_IMP(a_pop_when_free, q_valid && !(out_valid_o && out_stall_i), q_pop, "pop missed")
  // An accepted transaction leaves the queue non-empty on the next cycle.
  `BLPG_ASSERT_NXT(a_push_lands, in_valid_i && !in_stall_o, q_valid, "accepted transaction lost")
  // A configuration write takes effect on the next cycle.
  `BLPG_ASSERT_NXT(a_cfg_write, cfg_we_i, stride_q == $past(cfg_wdata_i), "stride write lost")

endmodule
